/* src/keyboard_led_command_sequencer_unit_defines.svh */
// assertion macros for the keyboard led command sequencer
// no dependencies; included by the top level only
`ifndef KEYBOARD_LED_COMMAND_SEQUENCER_UNIT_DEFINES_SVH
`define KEYBOARD_LED_COMMAND_SEQUENCER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define KLCS_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("klcs assertion failed");
`define KLCS_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("klcs assertion failed");
`else
`define KLCS_ASSERT_IMP(name, clk, rst, ante, cons)
`define KLCS_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

/* src/klcs_pkg.sv */
// shared types and constants of the keyboard led command sequencer
// no dependencies
`default_nettype none
package klcs_pkg;

   localparam logic [7:0] CMD_SET_LEDS = 8'hED;
   localparam logic [7:0] RSP_ACK      = 8'hFA;
   localparam logic [7:0] RSP_RESEND   = 8'hFE;
   localparam logic [7:0] RSP_ERR_A    = 8'hFC;
   localparam logic [7:0] RSP_ERR_B    = 8'hFD;

   localparam logic [19:0] TIMEOUT_RESET  = 20'd500000;
   localparam logic [2:0]  TRIES_RESET    = 3'd3;
   localparam logic [2:0]  ATTEMPTS_RESET = 3'd3;

   // register index, taken from paddr[3:2]
   localparam logic [1:0] REG_TIMEOUT  = 2'd0;
   localparam logic [1:0] REG_TRIES    = 2'd1;
   localparam logic [1:0] REG_ATTEMPTS = 2'd2;

   localparam logic [1:0] IN_TICK  = 2'd0;
   localparam logic [1:0] IN_BYTE  = 2'd1;
   localparam logic [1:0] IN_START = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_CMD,
      PH_MASK
   } phase_type;

   typedef enum logic [2:0] {
      EV_TICK,
      EV_START,
      EV_MOUSE,
      EV_ACK,
      EV_RESEND,
      EV_ERROR
   } ev_kind_type;

   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_TX,
      ACT_MOUSE,
      ACT_FINISH
   } action_type;

   typedef struct packed {
      ev_kind_type kind;
      logic [7:0]  data;
   } event_type;

   typedef struct packed {
      logic [19:0] timeout;
      logic [2:0]  tries;
      logic [2:0]  attempts;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      phase_type  phase;
      logic [2:0] attempt;
   } back_status_type;

endpackage
`default_nettype wire

/* src/keyboard_led_command_sequencer_unit.sv */
// an accepted item is written into the event queue, then its result is taken into
// the result register
// throughput: one item per cycle while the queue is not full; the four-entry event
// queue lets the front end keep accepting while the result register is stalled
// reset: synchronous, active high; control registers return to their reset values
// at once, no clearing pass; the result payload and queue entries are not reset
`default_nettype none
`include "keyboard_led_command_sequencer_unit_defines.svh"
module keyboard_led_command_sequencer_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,   // kind
   input  wire logic [15:0] req_tdata,   // rx_byte[7:0], rx_aux[8], led_bits[11:9]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [1:0]       rsp_tuser,   // action
   output logic [15:0]      rsp_tdata,   // data_byte[7:0], success[8], resend_count[11:9]
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [19:0]                   timeout_ff;
   logic [2:0]                    tries_ff;
   logic [2:0]                    attempts_ff;
   logic                          csr_write;
   klcs_pkg::cfg_type             cfg;
   klcs_pkg::event_type           front_ev;
   logic                          front_valid;
   klcs_pkg::event_type           head_ev;
   klcs_pkg::queue_status_type    q_status;
   logic                          ev_pop;
   klcs_pkg::back_status_type     back_status;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff  <= klcs_pkg::TIMEOUT_RESET;
         tries_ff    <= klcs_pkg::TRIES_RESET;
         attempts_ff <= klcs_pkg::ATTEMPTS_RESET;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            klcs_pkg::REG_TIMEOUT:  timeout_ff  <= csr_pwdata[19:0];
            klcs_pkg::REG_TRIES:    tries_ff    <= csr_pwdata[2:0];
            klcs_pkg::REG_ATTEMPTS: attempts_ff <= csr_pwdata[2:0];
            default: begin
               timeout_ff <= timeout_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         klcs_pkg::REG_TIMEOUT:  csr_prdata = {12'd0, timeout_ff};
         klcs_pkg::REG_TRIES:    csr_prdata = {29'd0, tries_ff};
         klcs_pkg::REG_ATTEMPTS: csr_prdata = {29'd0, attempts_ff};
         default:                csr_prdata = 32'd0;
      endcase
   end

   assign cfg.timeout  = timeout_ff;
   assign cfg.tries    = tries_ff;
   assign cfg.attempts = attempts_ff;

   assign req_tready = ~q_status.full;

   klcs_front u_front (
      .kind       (req_tuser),
      .rx_byte    (req_tdata[7:0]),
      .rx_aux     (req_tdata[8]),
      .led_bits   (req_tdata[11:9]),
      .item_valid (req_tvalid & req_tready),
      .ev         (front_ev),
      .ev_valid   (front_valid)
   );

   klcs_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (front_valid),
      .push_ev (front_ev),
      .pop     (ev_pop),
      .head_ev (head_ev),
      .status  (q_status)
   );

   klcs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .ev         (head_ev),
      .ev_ready   (~q_status.empty),
      .ev_pop     (ev_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .status     (back_status)
   );

   // a busy sequencer always has an attempt under way
   `KLCS_ASSERT_IMP(a_busy_has_attempt, clock, reset,
      back_status.phase != klcs_pkg::PH_IDLE, back_status.attempt != 3'd0)
   // success is only ever flagged on a finish
   `KLCS_ASSERT_IMP(a_success_on_finish, clock, reset,
      rsp_tvalid && rsp_tuser != klcs_pkg::ACT_FINISH, !rsp_tdata[8])
   // a finish leaves the sequencer idle, unless more events wait in the queue
   `KLCS_ASSERT_IMP(a_finish_idle, clock, reset,
      rsp_tvalid && rsp_tuser == klcs_pkg::ACT_FINISH,
      back_status.phase == klcs_pkg::PH_IDLE || !q_status.empty)
   // the queue is never full and empty at once
   `KLCS_ASSERT_NXT(a_queue_sane, clock, reset,
      1'b1, !(q_status.full && q_status.empty))

endmodule
`default_nettype wire

/* src/klcs_front.sv */
// front end: classifies input items into sequencer events
// uses klcs_pkg
`default_nettype none
module klcs_front (
   input  wire logic [1:0]        kind,
   input  wire logic [7:0]        rx_byte,
   input  wire logic              rx_aux,
   input  wire logic [2:0]        led_bits,
   input  wire logic              item_valid,
   output klcs_pkg::event_type    ev,
   output logic                   ev_valid
);

   logic keep;

   always_comb begin
      keep    = 1'b0;
      ev.kind = klcs_pkg::EV_TICK;
      ev.data = 8'd0;
      case (kind)
         klcs_pkg::IN_TICK: begin
            keep = 1'b1;
         end
         klcs_pkg::IN_START: begin
            keep    = 1'b1;
            ev.kind = klcs_pkg::EV_START;
            ev.data = {5'd0, led_bits};
         end
         klcs_pkg::IN_BYTE: begin
            ev.data = rx_byte;
            if (rx_aux) begin
               keep    = 1'b1;
               ev.kind = klcs_pkg::EV_MOUSE;
            end else if (rx_byte == klcs_pkg::RSP_ACK) begin
               keep    = 1'b1;
               ev.kind = klcs_pkg::EV_ACK;
            end else if (rx_byte == klcs_pkg::RSP_RESEND) begin
               keep    = 1'b1;
               ev.kind = klcs_pkg::EV_RESEND;
            end else if (rx_byte == klcs_pkg::RSP_ERR_A || rx_byte == klcs_pkg::RSP_ERR_B) begin
               keep    = 1'b1;
               ev.kind = klcs_pkg::EV_ERROR;
            end
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   // other keyboard bytes and the unused kind never reach the queue
   assign ev_valid = item_valid & keep;

endmodule
`default_nettype wire

/* src/klcs_queue.sv */
// short event queue between front end and sequencer
// uses klcs_pkg
`default_nettype none
module klcs_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  klcs_pkg::event_type         push_ev,
   input  wire logic                   pop,
   output klcs_pkg::event_type         head_ev,
   output klcs_pkg::queue_status_type  status
);

   klcs_pkg::event_type                  entry_ff [klcs_pkg::QUEUE_DEPTH];
   logic [klcs_pkg::QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [klcs_pkg::QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [klcs_pkg::QUEUE_CNT_W-1:0]     count_ff, count_in;
   logic                                 do_push;
   logic                                 do_pop;

   assign status.full  = (count_ff == klcs_pkg::QUEUE_CNT_W'(klcs_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & ~status.empty;
   assign head_ev      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + (do_push ? klcs_pkg::QUEUE_PTR_W'(1) : '0);
      rd_ptr_in = rd_ptr_ff + (do_pop ? klcs_pkg::QUEUE_PTR_W'(1) : '0);
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + klcs_pkg::QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - klcs_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_ev;
      end
   end

endmodule
`default_nettype wire

/* src/klcs_back.sv */
// back end: set-leds handshake sequencer with registered result stage
// uses klcs_pkg
`default_nettype none
module klcs_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  klcs_pkg::cfg_type           cfg,
   input  klcs_pkg::event_type         ev,
   input  wire logic                   ev_ready,
   output logic                        ev_pop,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [1:0]                  rsp_tuser,
   output logic [15:0]                 rsp_tdata,
   output klcs_pkg::back_status_type   status
);

   klcs_pkg::phase_type phase_ff, phase_in;
   logic [2:0]          phase_try_ff, phase_try_in;
   logic [2:0]          attempt_ff, attempt_in;
   logic [19:0]         wait_ticks_ff, wait_ticks_in;
   logic [2:0]          held_mask_ff, held_mask_in;
   logic [2:0]          resends_ff, resends_in;

   logic                rsp_valid_ff, rsp_valid_in;
   klcs_pkg::action_type rsp_action_ff, rsp_action_in;
   logic [7:0]          rsp_byte_ff, rsp_byte_in;
   logic                rsp_ok_ff, rsp_ok_in;
   logic [2:0]          rsp_resends_ff, rsp_resends_in;

   logic                out_free;
   logic                busy;
   logic                emit;
   klcs_pkg::action_type act;
   logic [7:0]          act_byte;
   logic                act_ok;
   logic                fail;
   logic                start;
   logic                finish;
   logic                finish_ok;

   assign out_free = ~rsp_valid_ff | rsp_tready;
   assign ev_pop   = ev_ready & out_free;
   assign busy     = (phase_ff == klcs_pkg::PH_CMD) || (phase_ff == klcs_pkg::PH_MASK);

   always_comb begin
      phase_in      = phase_ff;
      phase_try_in  = phase_try_ff;
      attempt_in    = attempt_ff;
      wait_ticks_in = wait_ticks_ff;
      held_mask_in  = held_mask_ff;
      resends_in    = resends_ff;
      emit          = 1'b0;
      act           = klcs_pkg::ACT_NONE;
      act_byte      = 8'd0;
      act_ok        = 1'b0;
      fail          = 1'b0;
      start         = 1'b0;
      finish        = 1'b0;
      finish_ok     = 1'b0;

      if (ev_pop) begin
         case (ev.kind)
            klcs_pkg::EV_START: begin
               if (!busy) begin
                  held_mask_in = ev.data[2:0];
                  attempt_in   = 3'd1;
                  start        = 1'b1;
               end
            end
            klcs_pkg::EV_TICK: begin
               if (busy) begin
                  wait_ticks_in = wait_ticks_ff + 20'd1;
                  fail          = (wait_ticks_in >= cfg.timeout);
               end
            end
            klcs_pkg::EV_MOUSE: begin
               emit     = 1'b1;
               act      = klcs_pkg::ACT_MOUSE;
               act_byte = ev.data;
            end
            klcs_pkg::EV_ACK: begin
               if (phase_ff == klcs_pkg::PH_CMD) begin
                  phase_in      = klcs_pkg::PH_MASK;
                  phase_try_in  = 3'd1;
                  wait_ticks_in = 20'd0;
                  emit          = 1'b1;
                  act           = klcs_pkg::ACT_TX;
                  act_byte      = {5'd0, held_mask_ff};
               end else if (phase_ff == klcs_pkg::PH_MASK) begin
                  finish    = 1'b1;
                  finish_ok = 1'b1;
               end
            end
            klcs_pkg::EV_RESEND: begin
               if (busy) begin
                  if (resends_ff != 3'd7) begin
                     resends_in = resends_ff + 3'd1;
                  end
                  if (phase_try_ff < cfg.tries) begin
                     phase_try_in  = phase_try_ff + 3'd1;
                     wait_ticks_in = 20'd0;
                     emit          = 1'b1;
                     act           = klcs_pkg::ACT_TX;
                     act_byte      = (phase_ff == klcs_pkg::PH_MASK) ?
                                     {5'd0, held_mask_ff} : klcs_pkg::CMD_SET_LEDS;
                  end else begin
                     fail = 1'b1;
                  end
               end
            end
            klcs_pkg::EV_ERROR: begin
               fail = busy;
            end
            default: begin
               emit = 1'b0;
            end
         endcase
      end

      // a failed attempt restarts the command or gives up
      if (fail) begin
         if (attempt_ff >= cfg.attempts) begin
            finish = 1'b1;
         end else begin
            attempt_in = attempt_ff + 3'd1;
            start      = 1'b1;
         end
      end

      if (start) begin
         phase_in      = klcs_pkg::PH_CMD;
         phase_try_in  = 3'd1;
         wait_ticks_in = 20'd0;
         resends_in    = 3'd0;
         emit          = 1'b1;
         act           = klcs_pkg::ACT_TX;
         act_byte      = klcs_pkg::CMD_SET_LEDS;
      end

      if (finish) begin
         phase_in      = klcs_pkg::PH_IDLE;
         phase_try_in  = 3'd0;
         wait_ticks_in = 20'd0;
         emit          = 1'b1;
         act           = klcs_pkg::ACT_FINISH;
         act_byte      = 8'd0;
         act_ok        = finish_ok;
      end

      rsp_valid_in   = rsp_valid_ff;
      rsp_action_in  = rsp_action_ff;
      rsp_byte_in    = rsp_byte_ff;
      rsp_ok_in      = rsp_ok_ff;
      rsp_resends_in = rsp_resends_ff;
      if (out_free) begin
         rsp_valid_in   = emit;
         rsp_action_in  = act;
         rsp_byte_in    = act_byte;
         rsp_ok_in      = act_ok;
         rsp_resends_in = resends_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= klcs_pkg::PH_IDLE;
         phase_try_ff  <= 3'd0;
         attempt_ff    <= 3'd0;
         wait_ticks_ff <= 20'd0;
         held_mask_ff  <= 3'd0;
         resends_ff    <= 3'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         phase_try_ff  <= phase_try_in;
         attempt_ff    <= attempt_in;
         wait_ticks_ff <= wait_ticks_in;
         held_mask_ff  <= held_mask_in;
         resends_ff    <= resends_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_action_ff  <= rsp_action_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_ok_ff      <= rsp_ok_in;
      rsp_resends_ff <= rsp_resends_in;
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_tuser      = rsp_action_ff;
   assign rsp_tdata      = {4'd0, rsp_resends_ff, rsp_ok_ff, rsp_byte_ff};
   assign status.phase   = phase_ff;
   assign status.attempt = attempt_ff;

endmodule
`default_nettype wire

/* dv/tb.sv */
// testbench for keyboard_led_command_sequencer_unit: directed table, then random phases
// under several register settings, checked against an in-bench model of the 0xED handshake
// depends on klcs_pkg and the rtl top level
`timescale 1ns / 100ps
module tb;

   localparam logic [1:0] IN_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 12;
   localparam int PHASE_ITEMS = 58;
   localparam int STALL_CYCLES = 160;

   typedef struct packed {
      klcs_pkg::action_type action;
      logic [7:0] data_byte;
      logic       success;
      logic [2:0] resend_count;
   } action_item_type;

   typedef struct packed {
      logic            is_csr;
      logic            typed;
      logic [1:0]      kind;
      logic [7:0]      rx;
      logic            aux;
      logic [2:0]      mask;
      logic [1:0]      index;
      logic [31:0]     value;
      action_item_type want;
   } script_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;   // kind
   logic [15:0] req_tdata;   // rx_byte[7:0], rx_aux[8], led_bits[11:9]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [1:0]  rsp_tuser;   // action
   logic [15:0] rsp_tdata;   // data_byte[7:0], success[8], resend_count[11:9]
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // model of the sequencer and its registers
   klcs_pkg::phase_type sq_phase;
   logic [2:0]  sq_try;
   logic [2:0]  sq_attempt;
   logic [19:0] sq_ticks;
   logic [2:0]  sq_mask;
   logic [2:0]  sq_resends;
   logic [19:0] cfg_timeout;
   logic [2:0]  cfg_tries;
   logic [2:0]  cfg_attempts;

   action_item_type due_actions[$];
   script_row_type  script[$];
   action_item_type head;
   int fail_count = 0;
   int phase_count = 0;
   int idle_pct = 14;
   int resend_pct = 16;
   int stall_left = 0;
   bit stall_request = 0;
   int cycle_count = 0;

   keyboard_led_command_sequencer_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tuser   (rsp_tuser),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
         input logic [31:0] want);
      fail_count++;
      $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
   endtask

   function automatic action_item_type make_item(klcs_pkg::action_type act, logic [7:0] b,
         logic ok);
      action_item_type r;
      r.action = act;
      r.data_byte = b;
      r.success = ok;
      r.resend_count = sq_resends;
      return r;
   endfunction

   function automatic action_item_type open_attempt();
      sq_phase = klcs_pkg::PH_CMD;
      sq_try = 3'd1;
      sq_ticks = '0;
      sq_resends = '0;
      return make_item(klcs_pkg::ACT_TX, klcs_pkg::CMD_SET_LEDS, 1'b0);
   endfunction

   function automatic action_item_type close_transaction(logic ok);
      sq_phase = klcs_pkg::PH_IDLE;
      sq_try = '0;
      sq_ticks = '0;
      return make_item(klcs_pkg::ACT_FINISH, 8'h00, ok);
   endfunction

   // a zero attempt limit behaves like one, as the compare shows
   function automatic action_item_type fail_attempt();
      if (sq_attempt >= cfg_attempts) begin
         return close_transaction(1'b0);
      end
      sq_attempt = sq_attempt + 3'd1;
      return open_attempt();
   endfunction

   function automatic bit led_handshake_step(input logic [1:0] kind, input logic [7:0] rx,
         input logic aux, input logic [2:0] mask, output action_item_type res);
      bit busy;
      busy = (sq_phase == klcs_pkg::PH_CMD) || (sq_phase == klcs_pkg::PH_MASK);
      res = '0;
      if (kind == klcs_pkg::IN_START) begin
         if (busy) return 1'b0;
         sq_mask = mask;
         sq_attempt = 3'd1;
         res = open_attempt();
         return 1'b1;
      end
      if (kind == klcs_pkg::IN_TICK) begin
         if (!busy) return 1'b0;
         sq_ticks = sq_ticks + 20'd1;
         if (sq_ticks < cfg_timeout) return 1'b0;
         res = fail_attempt();
         return 1'b1;
      end
      if (kind != klcs_pkg::IN_BYTE) return 1'b0;
      // mouse bytes pass through whatever the phase
      if (aux) begin
         res = make_item(klcs_pkg::ACT_MOUSE, rx, 1'b0);
         return 1'b1;
      end
      if (!busy) return 1'b0;
      case (rx)
         klcs_pkg::RSP_ACK: begin
            if (sq_phase == klcs_pkg::PH_CMD) begin
               sq_phase = klcs_pkg::PH_MASK;
               sq_try = 3'd1;
               sq_ticks = '0;
               res = make_item(klcs_pkg::ACT_TX, {5'd0, sq_mask}, 1'b0);
            end else begin
               res = close_transaction(1'b1);
            end
            return 1'b1;
         end
         klcs_pkg::RSP_RESEND: begin
            if (sq_resends != 3'd7) sq_resends = sq_resends + 3'd1;
            if (sq_try < cfg_tries) begin
               sq_try = sq_try + 3'd1;
               sq_ticks = '0;
               res = make_item(klcs_pkg::ACT_TX,
                  (sq_phase == klcs_pkg::PH_MASK) ? {5'd0, sq_mask} : klcs_pkg::CMD_SET_LEDS,
                  1'b0);
            end else begin
               res = fail_attempt();
            end
            return 1'b1;
         end
         klcs_pkg::RSP_ERR_A, klcs_pkg::RSP_ERR_B: begin
            res = fail_attempt();
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic void add_item(logic [1:0] k, logic [7:0] b, logic a, logic [2:0] m);
      script_row_type r;
      r = '0;
      r.kind = k;
      r.rx = b;
      r.aux = a;
      r.mask = m;
      script.push_back(r);
   endfunction

   function automatic void add_given(logic [1:0] k, logic [7:0] b, logic a, logic [2:0] m,
         klcs_pkg::action_type act, logic [7:0] ob, logic ok, logic [2:0] rc);
      script_row_type r;
      r = '0;
      r.typed = 1'b1;
      r.kind = k;
      r.rx = b;
      r.aux = a;
      r.mask = m;
      r.want.action = act;
      r.want.data_byte = ob;
      r.want.success = ok;
      r.want.resend_count = rc;
      script.push_back(r);
   endfunction

   function automatic void add_csr(logic [1:0] idx, logic [31:0] v);
      script_row_type r;
      r = '0;
      r.is_csr = 1'b1;
      r.index = idx;
      r.value = v;
      script.push_back(r);
   endfunction

   task automatic send_item(input logic [1:0] kind, input logic [7:0] rx, input logic aux,
         input logic [2:0] mask, input logic typed, input action_item_type want);
      action_item_type got;
      bit has_result;
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = kind;
      req_tdata = {4'd0, mask, aux, rx};
      do @(posedge clock); while (!req_tready);
      has_result = led_handshake_step(kind, rx, aux, mask, got);
      if (typed) begin
         has_result = (want.action != klcs_pkg::ACT_NONE);
         got = want;
      end
      if (has_result) due_actions.push_back(got);
      phase_count++;
   endtask

   // sender goes quiet until every outstanding result has been seen
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (due_actions.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic [1:0] index, input logic [31:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {index, 2'b00};
      csr_pwdata = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         klcs_pkg::REG_TIMEOUT:  cfg_timeout = value[19:0];
         klcs_pkg::REG_TRIES:    cfg_tries = value[2:0];
         klcs_pkg::REG_ATTEMPTS: cfg_attempts = value[2:0];
         default: ;
      endcase
      // read back the same register
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== value) report_mismatch("register read", csr_prdata, value);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic pick_item(output logic [1:0] kind, output logic [7:0] rx,
         output logic aux, output logic [2:0] mask);
      int roll;
      kind = klcs_pkg::IN_BYTE;
      rx = 8'($urandom_range(255));
      aux = 1'($urandom_range(1));
      mask = 3'($urandom_range(7));
      roll = $urandom_range(99);
      if (sq_phase == klcs_pkg::PH_IDLE) begin
         if (roll < 55) kind = klcs_pkg::IN_START;
         else if (roll < 70) aux = 1'b1;
         else if (roll < 80) kind = klcs_pkg::IN_TICK;
         else if (roll < 85) kind = IN_UNUSED;
      end else begin
         if (roll < 30) begin
            aux = 1'b0;
            rx = klcs_pkg::RSP_ACK;
         end else if (roll < 30 + resend_pct) begin
            aux = 1'b0;
            rx = klcs_pkg::RSP_RESEND;
         end else if (roll < 36 + resend_pct) begin
            aux = 1'b0;
            rx = ($urandom_range(1) != 0) ? klcs_pkg::RSP_ERR_A : klcs_pkg::RSP_ERR_B;
         end else if (roll < 54 + resend_pct) begin
            kind = klcs_pkg::IN_TICK;
         end else if (roll < 64 + resend_pct) begin
            aux = 1'b1;
         end else if (roll < 68 + resend_pct) begin
            kind = klcs_pkg::IN_START;
         end else if (roll < 71 + resend_pct) begin
            kind = IN_UNUSED;
         end else begin
            aux = 1'b0;
         end
      end
   endtask

   // receiver: random back-pressure plus one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_request) begin
            stall_request = 1'b0;
            stall_left = STALL_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            rsp_tready = ($urandom_range(99) >= idle_pct);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_actions.size() == 0) begin
            report_mismatch("unexpected transfer, action", 32'(rsp_tuser), 32'd0);
         end else begin
            head = due_actions.pop_front();
            if (rsp_tuser !== head.action)
               report_mismatch("action", 32'(rsp_tuser), 32'(head.action));
            if (rsp_tdata[7:0] !== head.data_byte)
               report_mismatch("data_byte", 32'(rsp_tdata[7:0]), 32'(head.data_byte));
            if (rsp_tdata[8] !== head.success)
               report_mismatch("success", 32'(rsp_tdata[8]), 32'(head.success));
            if (rsp_tdata[11:9] !== head.resend_count)
               report_mismatch("resend_count", 32'(rsp_tdata[11:9]),
                  32'(head.resend_count));
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      logic [1:0]  k;
      logic [7:0]  b;
      logic        a;
      logic [2:0]  m;
      logic [31:0] t_val;
      logic [31:0] r_val;
      logic [31:0] n_val;
      int p;
      bit stall_done;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      stall_done = 1'b0;
      cfg_timeout = klcs_pkg::TIMEOUT_RESET;
      cfg_tries = klcs_pkg::TRIES_RESET;
      cfg_attempts = klcs_pkg::ATTEMPTS_RESET;
      sq_phase = klcs_pkg::PH_IDLE;
      sq_try = '0;
      sq_attempt = '0;
      sq_ticks = '0;
      sq_mask = '0;
      sq_resends = '0;

      // idle behaviour straight after reset
      add_given(klcs_pkg::IN_TICK, 8'h00, 1'b0, 3'd0, klcs_pkg::ACT_NONE, 8'h00, 1'b0, 3'd0);
      add_given(klcs_pkg::IN_BYTE, klcs_pkg::RSP_ACK, 1'b0, 3'd0,
         klcs_pkg::ACT_NONE, 8'h00, 1'b0, 3'd0);
      add_given(klcs_pkg::IN_BYTE, 8'hFF, 1'b1, 3'd0, klcs_pkg::ACT_MOUSE, 8'hFF, 1'b0, 3'd0);
      add_given(klcs_pkg::IN_BYTE, 8'h00, 1'b1, 3'd7, klcs_pkg::ACT_MOUSE, 8'h00, 1'b0, 3'd0);
      add_given(IN_UNUSED, 8'hFF, 1'b1, 3'd7, klcs_pkg::ACT_NONE, 8'h00, 1'b0, 3'd0);
      // resends in the mask phase, then errors until the attempts run out
      add_given(klcs_pkg::IN_START, 8'h00, 1'b0, 3'd7,
         klcs_pkg::ACT_TX, klcs_pkg::CMD_SET_LEDS, 1'b0, 3'd0);
      add_given(klcs_pkg::IN_START, 8'h00, 1'b0, 3'd0,
         klcs_pkg::ACT_NONE, 8'h00, 1'b0, 3'd0);
      add_item(klcs_pkg::IN_BYTE, 8'h55, 1'b0, 3'd0);
      add_item(klcs_pkg::IN_BYTE, klcs_pkg::RSP_ACK, 1'b0, 3'd0);
      add_item(klcs_pkg::IN_BYTE, klcs_pkg::RSP_RESEND, 1'b0, 3'd0);
      add_item(klcs_pkg::IN_BYTE, klcs_pkg::RSP_RESEND, 1'b0, 3'd0);
      add_given(klcs_pkg::IN_BYTE, klcs_pkg::RSP_RESEND, 1'b0, 3'd0,
         klcs_pkg::ACT_TX, klcs_pkg::CMD_SET_LEDS, 1'b0, 3'd0);
      add_given(klcs_pkg::IN_BYTE, klcs_pkg::RSP_ERR_A, 1'b0, 3'd0,
         klcs_pkg::ACT_TX, klcs_pkg::CMD_SET_LEDS, 1'b0, 3'd0);
      add_given(klcs_pkg::IN_BYTE, klcs_pkg::RSP_ERR_B, 1'b0, 3'd0,
         klcs_pkg::ACT_FINISH, 8'h00, 1'b0, 3'd0);
      // clean transaction with a mouse byte in the middle
      add_item(klcs_pkg::IN_START, 8'hFF, 1'b1, 3'd0);
      add_item(klcs_pkg::IN_BYTE, klcs_pkg::RSP_ACK, 1'b0, 3'd0);
      add_item(klcs_pkg::IN_BYTE, klcs_pkg::RSP_ACK, 1'b1, 3'd0);
      add_item(klcs_pkg::IN_BYTE, klcs_pkg::RSP_ACK, 1'b0, 3'd0);
      // timeout on a single attempt
      add_csr(klcs_pkg::REG_TIMEOUT, 32'd2);
      add_csr(klcs_pkg::REG_ATTEMPTS, 32'd1);
      add_item(klcs_pkg::IN_START, 8'h00, 1'b0, 3'd5);
      add_item(klcs_pkg::IN_TICK, 8'h00, 1'b0, 3'd0);
      add_given(klcs_pkg::IN_TICK, 8'h00, 1'b0, 3'd0,
         klcs_pkg::ACT_FINISH, 8'h00, 1'b0, 3'd0);
      // zero limits behave as one
      add_csr(klcs_pkg::REG_TIMEOUT, 32'd0);
      add_csr(klcs_pkg::REG_TRIES, 32'd0);
      add_item(klcs_pkg::IN_START, 8'h00, 1'b0, 3'd2);
      add_item(klcs_pkg::IN_BYTE, klcs_pkg::RSP_RESEND, 1'b0, 3'd0);
      add_item(klcs_pkg::IN_START, 8'h00, 1'b0, 3'd6);
      add_item(klcs_pkg::IN_TICK, 8'h00, 1'b0, 3'd0);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (script[i]) begin
         if (script[i].is_csr) begin
            wait_drained();
            csr_access(script[i].index, script[i].value);
         end else begin
            send_item(script[i].kind, script[i].rx, script[i].aux, script[i].mask,
               script[i].typed, script[i].want);
         end
      end

      for (p = 0; p < 9; p++) begin
         wait_drained();
         case (p)
            0: begin
               t_val = 32'hFFFFF;
               r_val = 32'd7;
               n_val = 32'd7;
            end
            1: begin
               t_val = 32'd1;
               r_val = 32'd1;
               n_val = 32'd1;
            end
            2: begin
               t_val = 32'(klcs_pkg::TIMEOUT_RESET);
               r_val = 32'(klcs_pkg::TRIES_RESET);
               n_val = 32'(klcs_pkg::ATTEMPTS_RESET);
            end
            default: begin
               t_val = ($urandom_range(7) == 0) ? 32'd0 : 32'($urandom_range(12, 1));
               r_val = 32'($urandom_range(7));
               n_val = 32'($urandom_range(7));
            end
         endcase
         csr_access(klcs_pkg::REG_TIMEOUT, t_val);
         csr_access(klcs_pkg::REG_TRIES, r_val);
         csr_access(klcs_pkg::REG_ATTEMPTS, n_val);
         idle_pct = (p == 3) ? 0 : 14;
         resend_pct = (p == 0) ? 45 : 16;
         phase_count = 0;
         while (phase_count < PHASE_ITEMS) begin
            pick_item(k, b, a, m);
            send_item(k, b, a, m, 1'b0, '0);
            if (p == 5 && phase_count >= 5 && !stall_done) begin
               stall_request = 1'b1;
               stall_done = 1'b1;
            end
            if (p == 6 && phase_count == 30 && due_actions.size() != 0) wait_drained();
         end
      end

      wait_drained();
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
